[src/its_pkg.sv]
package its_pkg;

  // operation codes
  typedef enum logic [1:0] {
    OP_ACCOUNT = 2'd0,
    OP_READ_ENTRY = 2'd1,
    OP_READ_COUNTER = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // protocol classes
  localparam logic [1:0] PC_TCP = 2'd0;
  localparam logic [1:0] PC_UDP = 2'd1;
  localparam logic [1:0] PC_ICMP = 2'd2;
  localparam logic [1:0] PC_OTHER = 2'd3;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] PROTO_ICMP = 8'd1;

  localparam logic [15:0] BIN_STEP1 = 16'd250;
  localparam logic [15:0] BIN_STEP2 = 16'd500;
  localparam logic [15:0] BIN_STEP3 = 16'd750;
  localparam logic [15:0] BIN_STEP4 = 16'd1000;
  localparam logic [3:0] IHL_MASK = 4'hf;

  localparam int NUM_BINS = 5;
  localparam int NUM_PROTO = 4;
  // statistic counter indexes
  localparam logic [3:0] CIDX_PROTO0 = 4'd5;
  localparam logic [3:0] CIDX_LAST = 4'd8;

  localparam logic [31:0] MAX32 = 32'hffff_ffff;
  localparam logic [39:0] MAX40 = 40'hff_ffff_ffff;

  typedef struct packed {
    op_t op;
    logic [15:0] pkt_len;
    logic [7:0] ver_ihl;
    logic [7:0] proto_num;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [5:0] entry_index;
    logic [3:0] counter_index;
  } in_item_t;

  typedef struct packed {
    logic [5:0] header_bytes;
    logic [2:0] size_bin;
    logic [1:0] proto_class;
    logic [39:0] byte_total;
    logic table_full;
    logic entry_valid;
    logic [31:0] entry_addr;
    logic [31:0] entry_packets;
    logic [39:0] entry_bytes;
    logic [31:0] counter_value;
  } out_item_t;

  // one address table slot
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] packets;
    logic [39:0] bytes;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_ENTRY_RD,
    ST_ENTRY_CAP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_item;
    logic clr_idx;
    logic inc_idx;
    logic rd_scan;
    logic rd_entry;
    logic wr_hit;
    logic wr_new;
    logic sel_src;
    logic set_full;
    logic cap_entry;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t op;
    logic at_end;
    logic hit;
    logic room;
    logic entry_ok;
    logic out_free;
  } ctrl_sts_t;

  function automatic logic [31:0] inc32(input logic [31:0] v);
    inc32 = (v == MAX32) ? v : v + 32'd1;
  endfunction

  function automatic logic [39:0] add40(input logic [39:0] a, input logic [15:0] b);
    logic [40:0] s;
    s = {1'b0, a} + {25'd0, b};
    add40 = s[40] ? MAX40 : s[39:0];
  endfunction

endpackage

[src/its_if.sv]
interface its_in_if;
  import its_pkg::*;
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface its_out_if;
  import its_pkg::*;
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/its_ram.sv]
module its_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/its_ctrl.sv]
module its_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  its_pkg::op_t       in_op,
  output logic               in_ready,
  input  its_pkg::ctrl_sts_t sts,
  output its_pkg::ctrl_cmd_t cmd
);
  import its_pkg::*;

  state_t state_r, state_nxt;
  logic pass_r, pass_nxt;
  logic accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    pass_nxt = pass_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pass_nxt = 1'b0;
          unique case (in_op)
            OP_ACCOUNT: state_nxt = ST_SCAN_RD;
            OP_READ_ENTRY: state_nxt = ST_ENTRY_RD;
            default: state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_SCAN_RD: begin
        if (sts.at_end) begin
          pass_nxt = 1'b1;
          state_nxt = pass_r ? ST_FINISH : ST_SCAN_RD;
        end else begin
          state_nxt = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (sts.hit) begin
          pass_nxt = 1'b1;
          state_nxt = pass_r ? ST_FINISH : ST_SCAN_RD;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_ENTRY_RD: state_nxt = sts.entry_ok ? ST_ENTRY_CAP : ST_FINISH;
      ST_ENTRY_CAP: state_nxt = ST_FINISH;
      ST_FINISH: if (sts.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    cmd.sel_src = pass_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load_item = accept;
        cmd.clr_idx = accept;
      end
      ST_SCAN_RD: begin
        if (sts.at_end) begin
          cmd.wr_new = sts.room;
          cmd.set_full = !sts.room;
          cmd.clr_idx = 1'b1;
        end else begin
          cmd.rd_scan = 1'b1;
        end
      end
      ST_SCAN_CMP: begin
        cmd.wr_hit = sts.hit;
        cmd.clr_idx = sts.hit;
        cmd.inc_idx = !sts.hit;
      end
      ST_ENTRY_RD: cmd.rd_entry = sts.entry_ok;
      ST_ENTRY_CAP: cmd.cap_entry = 1'b1;
      ST_FINISH: cmd.load_out = sts.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pass_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r <= pass_nxt;
    end
  end

endmodule

[src/its_dpath.sv]
module its_dpath #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  its_pkg::in_item_t     in_data,
  input  its_pkg::ctrl_cmd_t    cmd,
  output its_pkg::ctrl_sts_t    sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output its_pkg::out_item_t    out_data
);
  import its_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  in_item_t item_r;
  logic [CW-1:0] count_r, idx_r;
  logic full_r;
  logic [39:0] bytes_seen_r;
  logic [31:0] hist_r [NUM_BINS];
  logic [31:0] proto_r [NUM_PROTO];
  logic ent_valid_r;
  slot_t ent_r;
  logic out_valid_r;
  out_item_t out_r, res;

  logic [31:0] key;
  logic [2:0] bin_in;
  logic [1:0] pc_in;
  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  slot_t ram_wdata, ram_rdata;
  logic [31:0] cval;
  logic [3:0] pidx;

  // size bin and protocol class of the incoming beat
  always_comb begin
    priority if (in_data.pkt_len >= BIN_STEP4) bin_in = 3'd4;
    else if (in_data.pkt_len >= BIN_STEP3) bin_in = 3'd3;
    else if (in_data.pkt_len >= BIN_STEP2) bin_in = 3'd2;
    else if (in_data.pkt_len >= BIN_STEP1) bin_in = 3'd1;
    else bin_in = 3'd0;
    priority if (in_data.proto_num == PROTO_TCP) pc_in = PC_TCP;
    else if (in_data.proto_num == PROTO_UDP) pc_in = PC_UDP;
    else if (in_data.proto_num == PROTO_ICMP) pc_in = PC_ICMP;
    else pc_in = PC_OTHER;
  end

  // address table
  assign key = cmd.sel_src ? item_r.src_addr : item_r.dst_addr;
  assign ram_we = cmd.wr_hit || cmd.wr_new;
  assign ram_waddr = cmd.wr_new ? count_r[AW-1:0] : idx_r[AW-1:0];
  assign ram_raddr = cmd.rd_entry ? AW'(item_r.entry_index) : idx_r[AW-1:0];

  always_comb begin
    if (cmd.wr_new) begin
      ram_wdata.addr = key;
      ram_wdata.packets = 32'd1;
      ram_wdata.bytes = {24'd0, item_r.pkt_len};
    end else begin
      ram_wdata.addr = ram_rdata.addr;
      ram_wdata.packets = inc32(ram_rdata.packets);
      ram_wdata.bytes = add40(ram_rdata.bytes, item_r.pkt_len);
    end
  end

  its_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // status to controller
  assign sts.op = item_r.op;
  assign sts.at_end = (idx_r == count_r);
  assign sts.hit = (ram_rdata.addr == key);
  assign sts.room = (count_r < CW'(TABLE_DEPTH));
  assign sts.entry_ok = (32'(item_r.entry_index) < 32'(count_r));
  assign sts.out_free = !out_valid_r || out_ready;

  // table fill and scan index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r <= '0;
    end else begin
      if (cmd.wr_new) count_r <= count_r + CW'(1);
      if (cmd.clr_idx) idx_r <= '0;
      else if (cmd.inc_idx) idx_r <= idx_r + CW'(1);
    end
  end

  // statistic counters, updated when an account beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      for (int i = 0; i < NUM_BINS; i++) hist_r[i] <= '0;
      for (int i = 0; i < NUM_PROTO; i++) proto_r[i] <= '0;
    end else if (cmd.load_item && in_data.op == OP_ACCOUNT) begin
      bytes_seen_r <= add40(bytes_seen_r, in_data.pkt_len);
      hist_r[bin_in] <= inc32(hist_r[bin_in]);
      proto_r[pc_in] <= inc32(proto_r[pc_in]);
    end
  end

  // item, full flag and captured entry
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
      full_r <= 1'b0;
      ent_valid_r <= 1'b0;
      ent_r <= '0;
    end else begin
      if (cmd.set_full) full_r <= 1'b1;
      if (cmd.cap_entry) begin
        ent_valid_r <= 1'b1;
        ent_r <= ram_rdata;
      end
    end
  end

  // selected statistic counter
  always_comb begin
    pidx = item_r.counter_index - CIDX_PROTO0;
    cval = '0;
    if (item_r.counter_index < CIDX_PROTO0) cval = hist_r[item_r.counter_index[2:0]];
    else if (item_r.counter_index <= CIDX_LAST) cval = proto_r[pidx[1:0]];
  end

  // result assembly
  always_comb begin
    res = '0;
    res.byte_total = bytes_seen_r;
    unique case (item_r.op)
      OP_ACCOUNT: begin
        res.header_bytes = {item_r.ver_ihl[3:0] & IHL_MASK, 2'b00};
        priority if (item_r.pkt_len >= BIN_STEP4) res.size_bin = 3'd4;
        else if (item_r.pkt_len >= BIN_STEP3) res.size_bin = 3'd3;
        else if (item_r.pkt_len >= BIN_STEP2) res.size_bin = 3'd2;
        else if (item_r.pkt_len >= BIN_STEP1) res.size_bin = 3'd1;
        else res.size_bin = 3'd0;
        priority if (item_r.proto_num == PROTO_TCP) res.proto_class = PC_TCP;
        else if (item_r.proto_num == PROTO_UDP) res.proto_class = PC_UDP;
        else if (item_r.proto_num == PROTO_ICMP) res.proto_class = PC_ICMP;
        else res.proto_class = PC_OTHER;
        res.table_full = full_r;
      end
      OP_READ_ENTRY: begin
        res.entry_valid = ent_valid_r;
        res.entry_addr = ent_r.addr;
        res.entry_packets = ent_r.packets;
        res.entry_bytes = ent_r.bytes;
      end
      OP_READ_COUNTER: res.counter_value = cval;
      default: res.byte_total = bytes_seen_r;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule

[src/ipv4_traffic_statistics.sv]
// IPv4 per-address traffic statistics.
// in_ch carries one operation per beat: account a packet, read an address
// table slot, or read a size-bin / protocol counter. out_ch returns exactly
// one result beat per input beat, in order; byte_total is always current.
// Accounting searches the address table held in a single-port-write RAM,
// one slot at a time (read, then compare), first for the destination
// and then for the source; a miss appends the address at the fill point.
// An account beat takes longer the more slots are filled; a hit ends its
// search early. The RAM read port and the scan loop set this time.
// The block holds one operation at a time; in_ch.ready is high when idle,
// also while the previous result still waits in the output register.
// When out_ch stalls, the finished result waits for the register to free.
// Reset (rst_n low, synchronous) empties the table through its fill count
// and clears all counters; no clearing pass is needed.
// All counters saturate; a full table sets table_full for new addresses.
module ipv4_traffic_statistics #(
  parameter int TABLE_DEPTH = 64
) (
  input logic clk,
  input logic rst_n,
  its_in_if.sink in_ch,
  its_out_if.source out_ch
);
  import its_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  its_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.data.op),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  its_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

endmodule

[verif/its_checker.sv]
`timescale 1ns / 100ps

module its_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input its_pkg::in_item_t in_data,
  input logic out_valid,
  input logic out_ready,
  input its_pkg::out_item_t out_data,
  output int err_count,
  output int pending
);
  import its_pkg::*;

  localparam int DEPTH = 64;

  // shadow copy of the statistics state
  logic [31:0] tbl_addr[DEPTH];
  logic tbl_used[DEPTH];
  logic [31:0] tbl_pkts[DEPTH];
  logic [39:0] tbl_bytes[DEPTH];
  logic [31:0] bin_count[NUM_BINS];
  logic [31:0] class_count[NUM_PROTO];
  logic [39:0] total_bytes;

  out_item_t result_q[$];

  assign pending = result_q.size();

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == MAX32) ? v : v + 32'd1;
  endfunction

  function automatic logic [39:0] sat_add(input logic [39:0] a, input logic [15:0] b);
    logic [40:0] s;
    s = {1'b0, a} + 41'(b);
    return s[40] ? MAX40 : s[39:0];
  endfunction

  // count one packet against an address; returns 1 when the address is new and no slot is free
  function automatic logic count_addr(input logic [31:0] addr, input logic [15:0] len);
    int free_idx;
    free_idx = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (tbl_used[i]) begin
        if (tbl_addr[i] == addr) begin
          tbl_pkts[i] = sat_inc(tbl_pkts[i]);
          tbl_bytes[i] = sat_add(tbl_bytes[i], len);
          return 1'b0;
        end
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (free_idx < 0) return 1'b1;
    tbl_used[free_idx] = 1'b1;
    tbl_addr[free_idx] = addr;
    tbl_pkts[free_idx] = 32'd1;
    tbl_bytes[free_idx] = 40'(len);
    return 1'b0;
  endfunction

  function automatic out_item_t predict_stats(input in_item_t it);
    out_item_t r;
    logic [2:0] bin;
    logic [1:0] pc;
    logic full;
    r = '0;
    case (it.op)
      OP_ACCOUNT: begin
        bin = (it.pkt_len >= BIN_STEP4) ? 3'd4 : 3'(it.pkt_len / BIN_STEP1);
        total_bytes = sat_add(total_bytes, it.pkt_len);
        bin_count[bin] = sat_inc(bin_count[bin]);
        full = count_addr(it.dst_addr, it.pkt_len);
        if (count_addr(it.src_addr, it.pkt_len)) full = 1'b1;
        if (it.proto_num == PROTO_TCP) pc = PC_TCP;
        else if (it.proto_num == PROTO_UDP) pc = PC_UDP;
        else if (it.proto_num == PROTO_ICMP) pc = PC_ICMP;
        else pc = PC_OTHER;
        class_count[pc] = sat_inc(class_count[pc]);
        r.header_bytes = {it.ver_ihl[3:0] & IHL_MASK, 2'b00};
        r.size_bin = bin;
        r.proto_class = pc;
        r.table_full = full;
      end
      OP_READ_ENTRY: begin
        if (tbl_used[it.entry_index]) begin
          r.entry_valid = 1'b1;
          r.entry_addr = tbl_addr[it.entry_index];
          r.entry_packets = tbl_pkts[it.entry_index];
          r.entry_bytes = tbl_bytes[it.entry_index];
        end
      end
      OP_READ_COUNTER: begin
        if (it.counter_index < CIDX_PROTO0) r.counter_value = bin_count[it.counter_index];
        else if (it.counter_index <= CIDX_LAST)
          r.counter_value = class_count[it.counter_index - CIDX_PROTO0];
      end
      default: ;
    endcase
    r.byte_total = total_bytes;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    $display("MISMATCH %0t %s: got %0h want %0h", $time, what, got, want);
    err_count++;
  endtask

  initial err_count = 0;

  // predict on input beats, compare on result beats
  always @(posedge clk) begin
    out_item_t w;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        tbl_used[i] = 1'b0;
        tbl_addr[i] = '0;
        tbl_pkts[i] = '0;
        tbl_bytes[i] = '0;
      end
      for (int i = 0; i < NUM_BINS; i++) bin_count[i] = '0;
      for (int i = 0; i < NUM_PROTO; i++) class_count[i] = '0;
      total_bytes = '0;
      result_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected beat", '0, '0);
        end else begin
          w = result_q.pop_front();
          if (out_data.header_bytes !== w.header_bytes)
            report_mismatch("header_bytes", out_data.header_bytes, w.header_bytes);
          if (out_data.size_bin !== w.size_bin)
            report_mismatch("size_bin", out_data.size_bin, w.size_bin);
          if (out_data.proto_class !== w.proto_class)
            report_mismatch("proto_class", out_data.proto_class, w.proto_class);
          if (out_data.byte_total !== w.byte_total)
            report_mismatch("byte_total", out_data.byte_total, w.byte_total);
          if (out_data.table_full !== w.table_full)
            report_mismatch("table_full", out_data.table_full, w.table_full);
          if (out_data.entry_valid !== w.entry_valid)
            report_mismatch("entry_valid", out_data.entry_valid, w.entry_valid);
          if (out_data.entry_addr !== w.entry_addr)
            report_mismatch("entry_addr", out_data.entry_addr, w.entry_addr);
          if (out_data.entry_packets !== w.entry_packets)
            report_mismatch("entry_packets", out_data.entry_packets, w.entry_packets);
          if (out_data.entry_bytes !== w.entry_bytes)
            report_mismatch("entry_bytes", out_data.entry_bytes, w.entry_bytes);
          if (out_data.counter_value !== w.counter_value)
            report_mismatch("counter_value", out_data.counter_value, w.counter_value);
        end
      end
      if (in_valid && in_ready) result_q = {result_q, predict_stats(in_data)};
    end
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import its_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  int err_count;
  int pending;
  int idle_cycles;
  logic hold_off;
  logic stim_done;
  logic [31:0] addr_pool[80];

  its_in_if in_ch();
  its_out_if out_ch();

  ipv4_traffic_statistics dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  its_checker chk (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .in_data(in_ch.data),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_data(out_ch.data),
    .err_count(err_count),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length: mostly short, sometimes long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // valid stays high into the next beat when there is no gap
  task automatic send_beat(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic in_item_t random_fields();
    in_item_t it;
    it.op = op_t'($urandom_range(0, 3));
    it.pkt_len = 16'($urandom);
    it.ver_ihl = 8'($urandom);
    it.proto_num = 8'($urandom);
    it.src_addr = $urandom;
    it.dst_addr = $urandom;
    it.entry_index = 6'($urandom);
    it.counter_index = 4'($urandom);
    return it;
  endfunction

  function automatic in_item_t account_pkt(input logic [15:0] len, input logic [7:0] proto,
                                           input logic [31:0] src, input logic [31:0] dst);
    in_item_t it;
    it = random_fields();
    it.op = OP_ACCOUNT;
    it.pkt_len = len;
    it.proto_num = proto;
    it.src_addr = src;
    it.dst_addr = dst;
    return it;
  endfunction

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (hold_off) out_ch.ready <= 1'b0;
    else if ($urandom_range(0, 99) < 12) out_ch.ready <= 1'b0;
    else if ($urandom_range(0, 99) < 2) out_ch.ready <= 1'b0;
    else out_ch.ready <= 1'b1;
  end

  initial begin
    hold_off = 1'b0;
    wait (stim_done === 1'b0);
    repeat (3000) @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  // watchdog on cycles with no beat
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    int sel;
    stim_done = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < 80; i++) addr_pool[i] = $urandom;
    addr_pool[0] = 32'h0;
    addr_pool[1] = 32'hffff_ffff;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: read empty state, length and protocol corners
    it = random_fields(); it.op = OP_READ_ENTRY; it.entry_index = 6'd0; send_beat(it);
    it = random_fields(); it.op = OP_READ_COUNTER; it.counter_index = 4'd0; send_beat(it);
    send_beat(account_pkt(16'd0, PROTO_TCP, 32'h0, 32'hffff_ffff));
    send_beat(account_pkt(16'd249, PROTO_UDP, 32'h0a00_0001, 32'h0a00_0001));
    send_beat(account_pkt(16'd250, PROTO_ICMP, 32'h0, 32'h0a00_0001));
    send_beat(account_pkt(16'd999, 8'd0, 32'h0, 32'hffff_ffff));
    send_beat(account_pkt(16'd1000, 8'hff, 32'hc0a8_0001, 32'h0));
    send_beat(account_pkt(16'hffff, PROTO_TCP, 32'hffff_ffff, 32'h0));
    for (int c = 0; c < 16; c++) begin
      it = random_fields(); it.op = OP_READ_COUNTER; it.counter_index = 4'(c); send_beat(it);
    end
    it = random_fields(); it.op = OP_NONE; send_beat(it);
    for (int e = 0; e < 4; e++) begin
      it = random_fields(); it.op = OP_READ_ENTRY; it.entry_index = 6'(e); send_beat(it);
    end

    // random: mostly accounting from a pool larger than the table, so it fills
    for (int n = 0; n < 1560; n++) begin
      it = random_fields();
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        it.op = OP_ACCOUNT;
        it.src_addr = addr_pool[$urandom_range(0, 79)];
        it.dst_addr = ($urandom_range(0, 9) == 0) ? it.src_addr : addr_pool[$urandom_range(0, 79)];
        if ($urandom_range(0, 1)) it.pkt_len = 16'($urandom_range(0, 1100));
        sel = $urandom_range(0, 7);
        if (sel == 0) it.proto_num = PROTO_TCP;
        else if (sel == 1) it.proto_num = PROTO_UDP;
        else if (sel == 2) it.proto_num = PROTO_ICMP;
      end else if (sel < 85) begin
        it.op = OP_READ_ENTRY;
      end else if (sel < 97) begin
        it.op = OP_READ_COUNTER;
      end
      send_beat(it);
    end

    // every slot once at the end
    for (int e = 0; e < 64; e++) begin
      it = random_fields(); it.op = OP_READ_ENTRY; it.entry_index = 6'(e); send_beat(it);
    end
    in_ch.valid <= 1'b0;

    stim_done = 1'b1;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
